[hw/rtl/acmr_pkg.sv]
// ----------------------------------------------------------------------------
// acmr_pkg: shared types and constants
// Frame identifiers, mode and register codes, and item structs used by the
// arm CAN message responder.
// ----------------------------------------------------------------------------
package acmr_pkg;

  localparam int IdentW   = 11;
  localparam int ByteW    = 8;
  localparam int NumBytes = 8;
  localparam int NumSpeed = 7;
  localparam int NumAxes  = 7;
  localparam int ModeW    = 4;
  localparam int LenW     = 4;
  localparam int NoticeW  = 2;
  localparam int PosW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int PhaseW   = 2;

  // frame identifiers
  localparam logic [IdentW-1:0] ID_STATUS   = 11'h350;
  localparam logic [IdentW-1:0] ID_POSITION = 11'h360;
  localparam logic [IdentW-1:0] ID_POLL     = 11'h37F;
  localparam logic [IdentW-1:0] ID_STOP     = 11'h370;
  localparam logic [IdentW-1:0] ID_CART     = 11'h371;
  localparam logic [IdentW-1:0] ID_JOINT    = 11'h374;
  localparam logic [IdentW-1:0] ID_FOLDOUT  = 11'h375;
  localparam logic [IdentW-1:0] ID_FOLDIN   = 11'h376;

  // status byte flag: message field is meaningful
  localparam logic [ByteW-1:0] MSG_FLAG = 8'h80;

  // arm messages that drive the announcement tracker
  localparam logic [ByteW-1:0] MSG_GRIP_READY   = 8'd2;
  localparam logic [ByteW-1:0] MSG_ANGLES_READY = 8'd3;

  // control modes
  localparam logic [ModeW-1:0] MODE_CART    = 4'd1;
  localparam logic [ModeW-1:0] MODE_JOINT   = 4'd4;
  localparam logic [ModeW-1:0] MODE_FOLDOUT = 4'd5;
  localparam logic [ModeW-1:0] MODE_FOLDIN  = 4'd6;

  // reply lengths
  localparam logic [LenW-1:0] LEN_NONE = 4'd0;
  localparam logic [LenW-1:0] LEN_FULL = 4'd8;

  // notice codes
  localparam logic [NoticeW-1:0] NOTICE_NONE   = 2'd0;
  localparam logic [NoticeW-1:0] NOTICE_GRIP   = 2'd1;
  localparam logic [NoticeW-1:0] NOTICE_ANGLES = 2'd2;

  // announcement tracker phases
  localparam logic [PhaseW-1:0] PHASE_DONE   = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_GRIP   = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_ANGLES = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CONTROL_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS4  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS5  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_AXIS6  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_GRIP   = 3'd7;

  typedef struct packed {
    logic [IdentW-1:0]                ident;
    logic [NumBytes-1:0][ByteW-1:0]   bytes;
  } rx_item_t;

  typedef struct packed {
    logic [IdentW-1:0]                ident;
    logic                             remote;
    logic [LenW-1:0]                  len;
    logic [NumBytes-1:0][ByteW-1:0]   bytes;
    logic [NoticeW-1:0]               notice;
  } tx_item_t;

  typedef struct packed {
    logic [ModeW-1:0]                 control_mode;
    logic [NumSpeed-1:0][ByteW-1:0]   speed;
  } cfg_t;

endpackage

[hw/rtl/acmr_if.sv]
// ----------------------------------------------------------------------------
// acmr_rx_if / acmr_tx_if: frame channels
// Valid/ready channels carrying a received frame and a reply frame.
// ----------------------------------------------------------------------------
interface acmr_rx_if;
  logic        valid;
  logic        ready;
  logic [10:0] rx_ident;
  logic [7:0]  rx_byte0;
  logic [7:0]  rx_byte1;
  logic [7:0]  rx_byte2;
  logic [7:0]  rx_byte3;
  logic [7:0]  rx_byte4;
  logic [7:0]  rx_byte5;
  logic [7:0]  rx_byte6;
  logic [7:0]  rx_byte7;

  modport source (
    output valid, rx_ident, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
           rx_byte4, rx_byte5, rx_byte6, rx_byte7,
    input  ready
  );
  modport sink (
    input  valid, rx_ident, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
           rx_byte4, rx_byte5, rx_byte6, rx_byte7,
    output ready
  );
endinterface

interface acmr_tx_if;
  logic        valid;
  logic        ready;
  logic [10:0] tx_ident;
  logic        tx_remote;
  logic [3:0]  tx_len;
  logic [7:0]  tx_byte0;
  logic [7:0]  tx_byte1;
  logic [7:0]  tx_byte2;
  logic [7:0]  tx_byte3;
  logic [7:0]  tx_byte4;
  logic [7:0]  tx_byte5;
  logic [7:0]  tx_byte6;
  logic [7:0]  tx_byte7;
  logic [1:0]  notice;

  modport source (
    output valid, tx_ident, tx_remote, tx_len, tx_byte0, tx_byte1, tx_byte2,
           tx_byte3, tx_byte4, tx_byte5, tx_byte6, tx_byte7, notice,
    input  ready
  );
  modport sink (
    input  valid, tx_ident, tx_remote, tx_len, tx_byte0, tx_byte1, tx_byte2,
           tx_byte3, tx_byte4, tx_byte5, tx_byte6, tx_byte7, notice,
    output ready
  );
endinterface

[hw/rtl/acmr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// acmr_cfg_regs: configuration registers
// Control mode and seven speed bytes, written through a plain write port.
// ----------------------------------------------------------------------------
module acmr_cfg_regs
  import acmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CONTROL_MODE) begin
        cfg.control_mode <= cfg_data[ModeW-1:0];
      end else begin
        // speed slot n sits at register index n+1
        cfg.speed[CfgIdxW'(cfg_index - CFG_SPEED_AXIS1)] <= cfg_data;
      end
    end
  end

endmodule

[hw/rtl/acmr_reply.sv]
// ----------------------------------------------------------------------------
// acmr_reply: frame decode, arm state and held reply frame
// Updates arm state and the announcement tracker from one frame and builds
// the reply into the held frame, which doubles as the result register.
// ----------------------------------------------------------------------------
module acmr_reply
  import acmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  rx_item_t item,
  input  cfg_t     cfg,
  output tx_item_t reply
);

  logic [ByteW-1:0]               arm_status;
  logic [ByteW-1:0]               arm_message;
  logic [NumAxes-1:0][PosW-1:0]   axis_position;
  logic [PhaseW-1:0]              announce_phase;
  logic [IdentW-1:0]              held_ident;
  logic [LenW-1:0]                held_len;
  logic [NumBytes-1:0][ByteW-1:0] held_bytes;
  logic [NoticeW-1:0]             notice;

  logic [PhaseW-1:0]              announce_phase_next;
  logic [IdentW-1:0]              held_ident_next;
  logic [LenW-1:0]                held_len_next;
  logic [NumBytes-1:0][ByteW-1:0] held_bytes_next;
  logic [NoticeW-1:0]             notice_next;
  logic                           is_status;
  logic                           is_position;
  logic                           flagged;

  assign is_status   = (item.ident == ID_STATUS);
  assign is_position = (item.ident == ID_POSITION);
  assign flagged     = (item.bytes[0] & MSG_FLAG) != '0;

  // announcement tracker
  always_comb begin
    announce_phase_next = announce_phase;
    notice_next         = NOTICE_NONE;
    if (is_status && flagged) begin
      if (item.bytes[1] == MSG_GRIP_READY && announce_phase == PHASE_GRIP) begin
        announce_phase_next = PHASE_ANGLES;
        notice_next         = NOTICE_GRIP;
      end else if (item.bytes[1] == MSG_ANGLES_READY &&
                   announce_phase == PHASE_ANGLES) begin
        announce_phase_next = PHASE_DONE;
        notice_next         = NOTICE_ANGLES;
      end
    end
  end

  // reply frame
  always_comb begin
    held_ident_next = held_ident;
    held_len_next   = held_len;
    held_bytes_next = held_bytes;
    if (is_status || is_position) begin
      held_ident_next = item.ident;
      held_len_next   = LEN_NONE;
    end else if (item.ident == ID_POLL) begin
      if (cfg.control_mode == MODE_CART || cfg.control_mode == MODE_JOINT) begin
        held_ident_next = (cfg.control_mode == MODE_CART) ? ID_CART : ID_JOINT;
        held_len_next   = LEN_FULL;
        held_bytes_next = {cfg.speed, {ByteW{1'b0}}};
      end else if (cfg.control_mode == MODE_FOLDOUT) begin
        held_ident_next = ID_FOLDOUT;
        held_len_next   = LEN_NONE;
      end else if (cfg.control_mode == MODE_FOLDIN) begin
        held_ident_next = ID_FOLDIN;
        held_len_next   = LEN_NONE;
      end else begin
        held_ident_next = ID_STOP;
        held_len_next   = LEN_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      announce_phase <= PHASE_GRIP;
      held_ident     <= '0;
      held_len       <= '0;
      held_bytes     <= '0;
      arm_status     <= '0;
      arm_message    <= '0;
      axis_position  <= '0;
      notice         <= NOTICE_NONE;
    end else if (load) begin
      announce_phase <= announce_phase_next;
      held_ident     <= held_ident_next;
      held_len       <= held_len_next;
      held_bytes     <= held_bytes_next;
      notice         <= notice_next;
      if (is_status) begin
        arm_status       <= item.bytes[0];
        arm_message      <= item.bytes[1];
        axis_position[0] <= {item.bytes[2], item.bytes[3]};
        axis_position[1] <= {item.bytes[4], item.bytes[5]};
        axis_position[2] <= {item.bytes[6], item.bytes[7]};
      end
      if (is_position) begin
        axis_position[3] <= {item.bytes[0], item.bytes[1]};
        axis_position[4] <= {item.bytes[2], item.bytes[3]};
        axis_position[5] <= {item.bytes[4], item.bytes[5]};
        axis_position[6] <= {item.bytes[6], item.bytes[7]};
      end
    end
  end

  assign reply.ident  = held_ident;
  assign reply.remote = 1'b0;
  assign reply.len    = held_len;
  assign reply.bytes  = held_bytes;
  assign reply.notice = notice;

endmodule

[hw/rtl/arm_can_message_responder.sv]
// ----------------------------------------------------------------------------
// arm_can_message_responder: robot arm CAN reply engine
// Turns each received CAN frame into exactly one reply frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx : received frames (identifier + 8 data bytes), valid/ready.
//   tx : reply frames (identifier, remote bit, length, 8 bytes, notice).
//   cfg_we / cfg_index / cfg_data : write-only config port; index 0 is the
//        control mode, 1..7 the speed bytes. Write only while idle.
// Path: a frame taken on rx is registered in the input register, then goes
//   through decode into the held reply frame, which drives tx.
// Throughput: one item per cycle while tx takes each reply; the input register
//   and the held-frame result register form a two-stage valid/ready pipeline.
// Status and position frames update the arm state and echo their own
//   identifier with length 0; a poll frame gets a mode command; unknown
//   identifiers resend the held frame. Notice flags gripper ready and then
//   angles ready, once each.
// Reset: clears both stage valids, the arm state and the held frame; the
//   announcement tracker starts waiting for gripper ready.
// Stall: while tx is not taken the held frame stays put, the input register
//   fills, and rx.ready drops once both stages are full.
// ----------------------------------------------------------------------------
module arm_can_message_responder
  import acmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  acmr_rx_if.sink            rx,
  acmr_tx_if.source          tx,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  cfg_t     cfg;
  rx_item_t in_item;
  rx_item_t in_q;
  tx_item_t reply;
  logic     in_valid;   // input register holds an item
  logic     out_valid;  // held frame is an undelivered result
  logic     out_load;   // input item moves into the result stage
  logic     out_free;

  acmr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_item.ident = rx.rx_ident;
  assign in_item.bytes = {rx.rx_byte7, rx.rx_byte6, rx.rx_byte5, rx.rx_byte4,
                          rx.rx_byte3, rx.rx_byte2, rx.rx_byte1, rx.rx_byte0};

  // pipeline handshake
  assign out_free = !out_valid || tx.ready;
  assign out_load = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  // input register payload, no reset needed
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_q <= in_item;
    end
  end

  acmr_reply u_reply (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .item  (in_q),
    .cfg   (cfg),
    .reply (reply)
  );

  assign tx.valid     = out_valid;
  assign tx.tx_ident  = reply.ident;
  assign tx.tx_remote = reply.remote;
  assign tx.tx_len    = reply.len;
  assign tx.tx_byte0  = reply.bytes[0];
  assign tx.tx_byte1  = reply.bytes[1];
  assign tx.tx_byte2  = reply.bytes[2];
  assign tx.tx_byte3  = reply.bytes[3];
  assign tx.tx_byte4  = reply.bytes[4];
  assign tx.tx_byte5  = reply.bytes[5];
  assign tx.tx_byte6  = reply.bytes[6];
  assign tx.tx_byte7  = reply.bytes[7];
  assign tx.notice    = reply.notice;

endmodule
